// ----- rtl/sda_pkg.sv -----
package sda_pkg;

	// Channel count and fixed-point layout.
	localparam int NUM_CH = 6;
	localparam int LOG_BITS = 24;
	localparam int OUT_FRAC = 20;
	localparam int EXP_W = 40;
	localparam int L_W = 30;
	localparam int COEF_W = 23;
	localparam int RATE_W = 21;
	localparam int ACC_W = 56;
	localparam int QUEUE_DEPTH = 2;
	localparam int FRAC_BITS_DEF = 20;
	localparam int SUM_WIDTH_DEF = 40;

	// Logarithm offsets in Q24.
	localparam longint LOG2_FIVE_Q24 = 38955489;
	localparam longint LOG2_400_Q24 = 145019842;
	localparam longint unsigned LOG2_E_Q24 = 64'd24204406;
	localparam logic signed [L_W-1:0] OFF_Q8 = L_W'((64'd8 << LOG_BITS) + LOG2_FIVE_Q24);
	localparam logic signed [L_W-1:0] OFF_SPEED = L_W'(LOG2_400_Q24);

	// Exponents and rates in Q20.
	localparam logic signed [COEF_W-1:0] LAM [NUM_CH] =
		'{23'sd408945, 23'sd482345, 23'sd408945, 23'sd440402, 23'sd429916, 23'sd1352663};
	localparam logic signed [COEF_W-1:0] BET [NUM_CH] =
		'{23'sd838861, 23'sd188744, 23'sd2432696, 23'sd1310720, 23'sd1677722, 23'sd2516582};
	localparam logic signed [COEF_W-1:0] GAM [NUM_CH] =
		'{23'sd912261, 23'sd702546, 23'sd1384120, 23'sd1352663, 23'sd723517, 23'sd555745};
	localparam longint unsigned RATE [NUM_CH] =
		'{64'd408945, 64'd734003, 64'd32506, 64'd608174, 64'd1205862, 64'd922747};

	// Decay exponent per channel: -(rate * log2(e) / 12) in Q24, rounded.
	localparam longint unsigned DEN = 64'd12 << 20;
	localparam longint unsigned RND6 = 64'd6 << 20;
	localparam logic signed [EXP_W-1:0] DE [NUM_CH] = '{
		-EXP_W'((RATE[0] * LOG2_E_Q24 + RND6) / DEN),
		-EXP_W'((RATE[1] * LOG2_E_Q24 + RND6) / DEN),
		-EXP_W'((RATE[2] * LOG2_E_Q24 + RND6) / DEN),
		-EXP_W'((RATE[3] * LOG2_E_Q24 + RND6) / DEN),
		-EXP_W'((RATE[4] * LOG2_E_Q24 + RND6) / DEN),
		-EXP_W'((RATE[5] * LOG2_E_Q24 + RND6) / DEN)
	};

	// Integer square root, used only to build the root table.
	function automatic longint unsigned isqrt64(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		longint unsigned v;
		r = 0;
		b = 64'd1 << 62;
		v = x;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-k) in Q30.
	function automatic logic [31:0] root_val(input int k);
		longint unsigned t;
		t = 64'd1 << 31;
		for (int j = 1; j <= k; j++) t = isqrt64(t << 30);
		return 32'(t);
	endfunction

	localparam logic [31:0] ROOT_TAB [25] = '{
		root_val(0), root_val(1), root_val(2), root_val(3), root_val(4),
		root_val(5), root_val(6), root_val(7), root_val(8), root_val(9),
		root_val(10), root_val(11), root_val(12), root_val(13), root_val(14),
		root_val(15), root_val(16), root_val(17), root_val(18), root_val(19),
		root_val(20), root_val(21), root_val(22), root_val(23), root_val(24)
	};

	// One classified sample, as passed from the front to the back.
	typedef struct packed {
		logic restart;
		logic live;
		logic signed [L_W-1:0] ln;
		logic signed [L_W-1:0] lv;
		logic signed [L_W-1:0] lb;
	} item_t;

	// Request to and response from the shared exp2 unit.
	typedef struct packed {
		logic start;
		logic signed [EXP_W-1:0] e;
		logic [5:0] fb;
	} exp_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [63:0] value;
	} exp_rsp_t;

endpackage

// ----- rtl/storm_driver_decay_accumulator.sv -----
// From input transfer to result, a live sample passes through the front (three
// logarithms), the queue, the back (six channels, each with two passes through the
// shared exp2 unit) and the output register. The back sequencer limits the sample rate;
// while it works, the front and a two-entry queue take the next samples.
// Reset clears all six running sums, empties the queue and drops any result.
module storm_driver_decay_accumulator import sda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [47:0] s_tdata, // density[15:0], speed[26:16], southward_field[42:27]
	input logic s_tuser, // restart
	output logic m_tvalid,
	input logic m_tready,
	output logic [191:0] m_tdata // w_one, w_two, w_three, w_four, w_five, w_six
);

	logic push_valid;
	logic push_ready;
	item_t push_data;
	logic pop_valid;
	logic pop_ready;
	item_t pop_data;

	sda_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	sda_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	sda_back #(
		.FRAC_BITS(FRAC_BITS),
		.SUM_WIDTH(SUM_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ----- rtl/sda_front.sv -----
module sda_front import sda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [47:0] s_tdata, // density[15:0], speed[26:16], southward_field[42:27]
	input logic s_tuser, // restart
	output logic push_valid,
	input logic push_ready,
	output item_t push_data
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_LOG = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t state_q;
	logic restart_q;
	logic live_q;
	logic [15:0] n_q;
	logic [10:0] v_q;
	logic [15:0] b_q;
	logic [1:0] j_q;
	logic [4:0] k_q;
	logic [31:0] m_q;
	logic [28:0] r_q;
	logic signed [L_W-1:0] l_q [3];

	logic [15:0] x_sel;
	logic [31:0] m_init;
	logic [28:0] r_init;
	logic [63:0] sq;
	logic [32:0] m2;
	logic [31:0] m_next;
	logic [28:0] r_next;
	logic signed [L_W-1:0] l_res;
	logic [15:0] s_n;
	logic [15:0] s_b;
	logic [10:0] s_v;

	assign s_n = s_tdata[15:0];
	assign s_v = s_tdata[26:16];
	assign s_b = s_tdata[42:27];

	// Operand for the next logarithm: the accepted density, or the stored speed or field.
	always_comb begin
		unique case (j_q)
			2'd0: x_sel = (state_q == F_IDLE) ? s_n : n_q;
			2'd1: x_sel = {5'b0, v_q};
			default: x_sel = b_q;
		endcase
	end

	// Normalize the operand so that its top bit lands at bit 31.
	always_comb begin
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (x_sel[i]) p = 5'(i);
		end
		m_init = 32'(x_sel) << (5'd31 - p);
		r_init = 29'(p) << LOG_BITS;
	end

	// One squaring step yields one fraction bit.
	always_comb begin
		sq = 64'(m_q) * 64'(m_q);
		m2 = sq[63:31];
		m_next = m2[32] ? m2[32:1] : m2[31:0];
		r_next = r_q;
		if (m2[32]) r_next[5'(LOG_BITS) - k_q] = 1'b1;
		if (j_q == 2'd1) l_res = signed'({1'b0, r_next}) - OFF_SPEED;
		else l_res = signed'({1'b0, r_next}) - OFF_Q8;
	end

	assign s_tready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_data = '{restart: restart_q, live: live_q,
		ln: l_q[0], lv: l_q[1], lb: l_q[2]};

	// Accept a sample, take its three logarithms (or zero them if any field is zero), then hand it on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			j_q <= 2'd0;
			k_q <= 5'd1;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						restart_q <= s_tuser;
						n_q <= s_n;
						v_q <= s_v;
						b_q <= s_b;
						j_q <= 2'd0;
						k_q <= 5'd1;
						if (s_n != 16'd0 && s_v != 11'd0 && s_b != 16'd0) begin
							live_q <= 1'b1;
							m_q <= m_init;
							r_q <= r_init;
							state_q <= F_LOG;
						end else begin
							live_q <= 1'b0;
							l_q[0] <= '0;
							l_q[1] <= '0;
							l_q[2] <= '0;
							state_q <= F_PUSH;
						end
					end
				end
				F_LOG: begin
					if (k_q == 5'(LOG_BITS)) begin
						l_q[j_q] <= l_res;
						k_q <= 5'd1;
						if (j_q == 2'd2) begin
							// Back to the density slot so the next accepted sample
							// is normalized from its own density.
							j_q <= 2'd0;
							state_q <= F_PUSH;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end else begin
						m_q <= m_next;
						r_q <= r_next;
						k_q <= k_q + 5'd1;
					end
				end
				F_PUSH: begin
					if (push_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
			// Load the next operand as soon as the previous logarithm is stored.
			if (state_q == F_LOG && k_q == 5'(LOG_BITS) && j_q != 2'd2) begin
				m_q <= m_init_next(j_q);
				r_q <= r_init_next(j_q);
			end
		end
	end

	// Normalized start values for speed and field, chosen by the step just finished.
	function automatic logic [31:0] m_init_next(input logic [1:0] j);
		logic [15:0] x;
		logic [4:0] p;
		x = (j == 2'd0) ? {5'b0, v_q} : b_q;
		p = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) p = 5'(i);
		end
		return 32'(x) << (5'd31 - p);
	endfunction

	function automatic logic [28:0] r_init_next(input logic [1:0] j);
		logic [15:0] x;
		logic [4:0] p;
		x = (j == 2'd0) ? {5'b0, v_q} : b_q;
		p = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) p = 5'(i);
		end
		return 29'(p) << LOG_BITS;
	endfunction

endmodule

// ----- rtl/sda_queue.sv -----
module sda_queue import sda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input item_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output item_t pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/sda_exp2.sv -----
module sda_exp2 import sda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input exp_req_t req,
	output exp_rsp_t rsp
);

	typedef enum logic [2:0] {
		X_IDLE = 3'b001,
		X_ITER = 3'b010,
		X_FIN = 3'b100
	} xstate_t;

	localparam logic signed [EXP_W-1:0] E_LO = -(EXP_W'(127) <<< LOG_BITS);
	localparam logic signed [EXP_W-1:0] E_HI = EXP_W'(63) <<< LOG_BITS;

	xstate_t state_q;
	logic [4:0] k_q;
	logic [31:0] m_q;
	logic [LOG_BITS-1:0] fr_q;
	logic signed [9:0] sh_q;
	logic [63:0] val_q;
	logic done_q;

	logic signed [EXP_W-LOG_BITS-1:0] ip;
	logic signed [9:0] sh_init;
	logic [63:0] mul;
	logic [63:0] mul_r;
	logic [31:0] m_step;
	logic [9:0] nsh;
	logic [63:0] shifted;

	assign rsp.busy = (state_q != X_IDLE);
	assign rsp.done = done_q;
	assign rsp.value = val_q;

	// Integer part of the exponent sets the final shift.
	always_comb begin
		ip = req.e[EXP_W-1:LOG_BITS];
		sh_init = 10'(ip) + signed'({4'b0, req.fb}) - 10'sd30;
	end

	// One fraction bit per step: multiply by 2^(2^-k) when the bit is set.
	always_comb begin
		mul = 64'(m_q) * 64'(ROOT_TAB[k_q]);
		mul_r = mul + (64'd1 << 29);
		m_step = fr_q[5'(LOG_BITS) - k_q] ? mul_r[61:30] : m_q;
	end

	// Scale the mantissa to the requested fraction width.
	always_comb begin
		nsh = 10'(-sh_q);
		if (sh_q >= 10'sd33) begin
			shifted = '1;
		end else if (sh_q >= 10'sd0) begin
			shifted = 64'(m_q) << sh_q[5:0];
		end else if (nsh >= 10'd40) begin
			shifted = '0;
		end else begin
			shifted = (64'(m_q) + (64'd1 << (nsh - 10'd1))) >> nsh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
			done_q <= 1'b0;
			k_q <= 5'd1;
			val_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				X_IDLE: begin
					if (req.start) begin
						if (req.e < E_LO) begin
							val_q <= '0;
							done_q <= 1'b1;
						end else if (req.e > E_HI) begin
							val_q <= '1;
							done_q <= 1'b1;
						end else begin
							fr_q <= req.e[LOG_BITS-1:0];
							sh_q <= sh_init;
							m_q <= 32'd1 << 30;
							k_q <= 5'd1;
							state_q <= X_ITER;
						end
					end
				end
				X_ITER: begin
					m_q <= m_step;
					k_q <= k_q + 5'd1;
					if (k_q == 5'(LOG_BITS)) state_q <= X_FIN;
				end
				X_FIN: begin
					val_q <= shifted;
					done_q <= 1'b1;
					state_q <= X_IDLE;
				end
				default: state_q <= X_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/sda_back.sv -----
module sda_back import sda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input item_t pop_data,
	output logic m_tvalid,
	input logic m_tready,
	output logic [32*NUM_CH-1:0] m_tdata // w_one[31:0] up to w_six[191:160]
);

	typedef enum logic [13:0] {
		B_IDLE = 14'b00000000000001,
		B_MAC = 14'b00000000000010,
		B_RND = 14'b00000000000100,
		B_TEXP = 14'b00000000001000,
		B_DEXP = 14'b00000000010000,
		B_MH = 14'b00000000100000,
		B_ML = 14'b00000001000000,
		B_ADD = 14'b00000010000000,
		B_SAT = 14'b00000100000000,
		B_OM = 14'b00001000000000,
		B_OL = 14'b00010000000000,
		B_CHK = 14'b00100000000000,
		B_DIV = 14'b01000000000000,
		B_NEXT = 14'b10000000000000
	} bstate_t;

	localparam int HI_W = SUM_WIDTH - 30;
	localparam logic [63:0] W_LIM = 64'd12 << 32;
	// Reciprocals of three: ceil(2^17/3) and ceil(2^19/3).
	localparam logic [15:0] DIV3_M17 = 16'd43691;
	localparam logic [17:0] DIV3_M19 = 18'd174763;

	bstate_t state_q;
	logic out_pend_q;
	item_t item_q;
	logic [2:0] ch_q;
	logic [1:0] k_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [SUM_WIDTH-1:0] sum_q [NUM_CH];
	logic [SUM_WIDTH-1:0] term_q;
	logic [30:0] d_q;
	logic [HI_W+30:0] ph_q;
	logic [60:0] pl_q;
	logic [SUM_WIDTH-1:0] sdec_q;
	logic [62:0] xh_q;
	logic osat_q;
	logic [63:0] x_q;
	logic [15:0] qh_q;
	logic [18:0] rl_q;
	logic [31:0] w_q [NUM_CH];
	logic [32*NUM_CH-1:0] out_q;
	logic m_valid_q;

	exp_req_t exp_req;
	exp_rsp_t exp_rsp;

	logic signed [COEF_W-1:0] coef;
	logic signed [L_W-1:0] lval;
	logic signed [ACC_W-1:0] acc_next;
	logic [ACC_W-1:0] a_abs;
	logic [ACC_W-1:0] a_rnd;
	logic signed [EXP_W-1:0] e_rnd;
	logic [SUM_WIDTH-1:0] cur_sum;
	logic [SUM_WIDTH:0] sat_sum;
	logic [64:0] tval_hi;
	logic [63:0] o64;
	logic [16:0] yh;
	logic [32:0] qh_prod;
	logic [15:0] qh;
	logic [16:0] rh_wide;
	logic [36:0] ql_prod;
	logic [17:0] ql;
	logic [RATE_W-1:0] rate_c;
	logic out_free;

	sda_exp2 u_exp2 (
		.clk(clk),
		.arst_n(arst_n),
		.req(exp_req),
		.rsp(exp_rsp)
	);

	assign cur_sum = sum_q[ch_q];
	assign rate_c = RATE_W'(RATE[ch_q]);
	assign out_free = !m_valid_q || m_tready;
	assign pop_ready = (state_q == B_IDLE) && !out_pend_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata = out_q;

	// Weighted sum of the three logarithms, one product per cycle.
	always_comb begin
		unique case (k_q)
			2'd0: begin
				coef = LAM[ch_q];
				lval = item_q.ln;
			end
			2'd1: begin
				coef = BET[ch_q];
				lval = item_q.lv;
			end
			default: begin
				coef = GAM[ch_q];
				lval = item_q.lb;
			end
		endcase
		acc_next = acc_q + ACC_W'(coef) * ACC_W'(lval);
	end

	// Round the Q44 sum to Q24, half away from zero.
	always_comb begin
		a_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		a_rnd = (a_abs + (ACC_W'(1) << 19)) >> 20;
		e_rnd = acc_q[ACC_W-1] ? -EXP_W'(a_rnd) : EXP_W'(a_rnd);
	end

	// Requests to the shared exp2 unit: the driver term for a live sample, then the decay factor.
	always_comb begin
		exp_req.start = 1'b0;
		exp_req.e = DE[ch_q];
		exp_req.fb = 6'd30;
		if (state_q == B_RND) begin
			exp_req.start = 1'b1;
			if (item_q.live) begin
				exp_req.e = e_rnd;
				exp_req.fb = 6'(FRAC_BITS);
			end
		end else if (state_q == B_TEXP && exp_rsp.done) begin
			exp_req.start = 1'b1;
		end
	end

	// Saturating sum update and the split of the sum for the output scaling.
	always_comb begin
		tval_hi = {1'b0, exp_rsp.value} >> SUM_WIDTH;
		sat_sum = {1'b0, sdec_q} + {1'b0, term_q};
		o64 = 64'(cur_sum) >> OUT_FRAC;
	end

	// Division by twelve: drop two bits, then divide by three in two halves of 17 bits,
	// each by a reciprocal multiplication that is exact over its input range.
	always_comb begin
		yh = x_q[35:19];
		qh_prod = 33'(yh) * 33'(DIV3_M17);
		qh = qh_prod[32:17];
		rh_wide = yh - 17'(qh) * 17'd3;
		ql_prod = 37'(rl_q) * 37'(DIV3_M19);
		ql = ql_prod[36:19];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_pend_q <= 1'b0;
			m_valid_q <= 1'b0;
			ch_q <= '0;
			k_q <= '0;
			for (int i = 0; i < NUM_CH; i++) sum_q[i] <= '0;
		end else begin
			// Output register: hold a result until its transfer completes.
			if (out_pend_q && out_free) begin
				for (int i = 0; i < NUM_CH; i++) out_q[32*i +: 32] <= w_q[i];
				m_valid_q <= 1'b1;
				out_pend_q <= 1'b0;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				B_IDLE: begin
					if (pop_valid && !out_pend_q) begin
						item_q <= pop_data;
						if (pop_data.restart) begin
							for (int i = 0; i < NUM_CH; i++) sum_q[i] <= '0;
						end
						ch_q <= '0;
						k_q <= '0;
						acc_q <= '0;
						state_q <= B_MAC;
					end
				end
				B_MAC: begin
					acc_q <= acc_next;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) state_q <= B_RND;
				end
				B_RND: begin
					if (item_q.live) begin
						state_q <= B_TEXP;
					end else begin
						term_q <= '0;
						state_q <= B_DEXP;
					end
				end
				B_TEXP: begin
					if (exp_rsp.done) begin
						term_q <= (tval_hi != '0) ? '1 : exp_rsp.value[SUM_WIDTH-1:0];
						state_q <= B_DEXP;
					end
				end
				B_DEXP: begin
					if (exp_rsp.done) begin
						d_q <= exp_rsp.value[30:0];
						state_q <= B_MH;
					end
				end
				B_MH: begin
					ph_q <= (HI_W+31)'(cur_sum[SUM_WIDTH-1:30]) * (HI_W+31)'(d_q);
					state_q <= B_ML;
				end
				B_ML: begin
					pl_q <= 61'(cur_sum[29:0]) * 61'(d_q);
					state_q <= B_ADD;
				end
				B_ADD: begin
					sdec_q <= SUM_WIDTH'(ph_q) + SUM_WIDTH'((pl_q + (61'd1 << 29)) >> 30);
					state_q <= B_SAT;
				end
				B_SAT: begin
					sum_q[ch_q] <= sat_sum[SUM_WIDTH] ? '1 : sat_sum[SUM_WIDTH-1:0];
					state_q <= B_OM;
				end
				B_OM: begin
					osat_q <= (o64[63:42] != '0);
					xh_q <= 63'(o64[41:0]) * 63'(rate_c);
					state_q <= B_OL;
				end
				B_OL: begin
					x_q <= 64'(xh_q) +
						64'((41'(cur_sum[OUT_FRAC-1:0]) * 41'(rate_c)) >> OUT_FRAC);
					state_q <= B_CHK;
				end
				B_CHK: begin
					if (osat_q || x_q >= W_LIM) begin
						w_q[ch_q] <= '1;
					end else begin
						qh_q <= qh;
						rl_q <= {rh_wide[1:0], x_q[18:2]};
					end
					state_q <= (osat_q || x_q >= W_LIM) ? B_NEXT : B_DIV;
				end
				B_DIV: begin
					w_q[ch_q] <= (32'(qh_q) << 17) + 32'(ql);
					state_q <= B_NEXT;
				end
				B_NEXT: begin
					if (ch_q == 3'(NUM_CH - 1)) begin
						out_pend_q <= 1'b1;
						state_q <= B_IDLE;
					end else begin
						ch_q <= ch_q + 3'd1;
						k_q <= '0;
						acc_q <= '0;
						state_q <= B_MAC;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_exp_free: assert property (@(posedge clk) disable iff (!arst_n)
		exp_req.start |-> !exp_rsp.busy)
		else $error("exp2 request while unit busy");
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= 3'(NUM_CH - 1))
		else $error("channel index out of range");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(out_pend_q))
		else $error("result shown without a finished item");
	a_no_pop_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |-> !out_pend_q)
		else $error("item taken while previous result unplaced");
`endif

endmodule
